### hw/rtl/spbb_pkg.sv
// ----------------------------------------------------------------------------
// spbb_pkg: shared types and constants for the spherical polygon bounding box
// Field widths, angle constants in micro-degrees and the words passed
// between the vertex, accumulate and box stages.
// ----------------------------------------------------------------------------
package spbb_pkg;

    localparam int LON_W  = 30;
    localparam int LAT_W  = 28;
    localparam int TOL_W  = 20;
    localparam int SUM_W  = 40;
    localparam int STEP_W = 31;
    localparam int ARITH_W = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(100);

    localparam logic signed [ARITH_W-1:0] QUARTER_TURN = 32'sd90000000;
    localparam logic signed [ARITH_W-1:0] HALF_TURN    = 32'sd180000000;
    localparam logic signed [ARITH_W-1:0] TRI_QUARTER  = 32'sd270000000;
    localparam logic signed [ARITH_W-1:0] FULL_TURN    = 32'sd360000000;
    localparam logic signed [ARITH_W-1:0] FIVE_QUARTER = 32'sd450000000;

    localparam logic signed [LON_W-1:0] LON_FULL     = 30'sd360000000;
    localparam logic signed [LON_W-1:0] LON_NEG_FULL = -30'sd360000000;
    localparam logic signed [LAT_W-1:0] LAT_NORTH    = 28'sd90000000;
    localparam logic signed [LAT_W-1:0] LAT_SOUTH    = -28'sd90000000;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic signed [1:0] POLE_SOUTH = -2'sd1;
    localparam logic signed [1:0] POLE_NONE  = 2'sd0;
    localparam logic signed [1:0] POLE_NORTH = 2'sd1;

    // per-vertex terms, worked out as the vertex is taken in
    typedef struct packed {
        logic signed [LON_W-1:0]  pos;   // 0..360 convention
        logic signed [LON_W-1:0]  sgn;   // -180..180 convention
        logic        [3:0]        quad;  // one-hot quadrant
        logic signed [STEP_W-1:0] step;  // wrapped longitude step
        logic signed [LAT_W-1:0]  lat;
        logic                     last;
    } t_vertex;

    // polygon state after its last vertex
    typedef struct packed {
        logic signed [LAT_W-1:0] lat_low;
        logic signed [LAT_W-1:0] lat_high;
        logic signed [LON_W-1:0] lo_pos;
        logic signed [LON_W-1:0] hi_pos;
        logic signed [LON_W-1:0] lo_sgn;
        logic signed [LON_W-1:0] hi_sgn;
        logic        [3:0]       quad;
        logic signed [SUM_W-1:0] step_sum;
        logic signed [SUM_W-1:0] lat_total;
    } t_snap;

endpackage

### hw/rtl/spherical_polygon_bounding_box_top.sv
// ----------------------------------------------------------------------------
// spherical_polygon_bounding_box_top: bounding box of a spherical polygon
// Vertex words in, one box word out per polygon on its last vertex.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one vertex word (longitude and
// latitude in signed micro-degrees, a last-vertex mark). Output channel:
// o_valid / i_stall carry one box word per polygon, sent for its marked
// vertex. A word moves at a clock edge with valid high and stall low.
// Throughput is one vertex per cycle unless a last vertex is held: vertex
// register, accumulator and box register are each one stage and each takes
// a new word every cycle unless stalled. From the edge that takes the last
// vertex, its state goes into the accumulator snapshot, then the box register.
// Vertices that are not last keep flowing while a box word waits on a stalled
// output; a further last vertex waits in the vertex register, holding the
// input, only once the snapshot and the box register both hold a word.
// The pole tolerance is written with i_cfg_we / i_cfg_wdata; write it only
// while no polygon is in flight.
// Reset (i_rst_n low at an edge) empties all stages, clears the polygon
// state and sets the pole tolerance to 100 micro-degrees.
// ----------------------------------------------------------------------------
module spherical_polygon_bounding_box_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [spbb_pkg::LON_W-1:0]    i_vertex_lon,
    input  logic signed [spbb_pkg::LAT_W-1:0]    i_vertex_lat,
    input  logic                                 i_last_vertex,
    input  logic                                 i_cfg_we,
    input  logic [spbb_pkg::TOL_W-1:0]           i_cfg_wdata,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [spbb_pkg::LON_W-1:0]    o_west_lon,
    output logic signed [spbb_pkg::LON_W-1:0]    o_east_lon,
    output logic signed [spbb_pkg::LAT_W-1:0]    o_south_lat,
    output logic signed [spbb_pkg::LAT_W-1:0]    o_north_lat,
    output logic signed [1:0]                    o_pole_code
);

    logic [spbb_pkg::TOL_W-1:0] r_pole_tolerance;

    logic              vtx_valid;
    spbb_pkg::t_vertex vtx_word;
    logic              vtx_take;
    logic              snap_valid;
    spbb_pkg::t_snap   snap;
    logic              snap_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_tolerance <= spbb_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_pole_tolerance <= i_cfg_wdata;
        end
    end

    spbb_vertex u_vertex (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_vertex_lon  (i_vertex_lon),
        .i_vertex_lat  (i_vertex_lat),
        .i_last_vertex (i_last_vertex),
        .i_take        (vtx_take),
        .o_valid       (vtx_valid),
        .o_word        (vtx_word)
    );

    spbb_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (vtx_valid),
        .i_word       (vtx_word),
        .o_take       (vtx_take),
        .i_snap_take  (snap_take),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    spbb_box u_box (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_snap_valid     (snap_valid),
        .i_snap           (snap),
        .o_snap_take      (snap_take),
        .i_pole_tolerance (r_pole_tolerance),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_west_lon       (o_west_lon),
        .o_east_lon       (o_east_lon),
        .o_south_lat      (o_south_lat),
        .o_north_lat      (o_north_lat),
        .o_pole_code      (o_pole_code)
    );

endmodule

### hw/rtl/spbb_vertex.sv
// ----------------------------------------------------------------------------
// spbb_vertex: vertex input register
// Takes a vertex word, normalizes its longitude, finds its quadrant and the
// wrapped step from the previous longitude, and holds the result.
// ----------------------------------------------------------------------------
module spbb_vertex (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [spbb_pkg::LON_W-1:0]    i_vertex_lon,
    input  logic signed [spbb_pkg::LAT_W-1:0]    i_vertex_lat,
    input  logic                                 i_last_vertex,
    input  logic                                 i_take,
    output logic                                 o_valid,
    output spbb_pkg::t_vertex                    o_word
);

    logic                                    r_valid;
    spbb_pkg::t_vertex                       r_word;
    logic signed [spbb_pkg::LON_W-1:0]       r_prev_lon;
    spbb_pkg::t_vertex                       n_word;

    logic signed [spbb_pkg::ARITH_W-1:0] lon_x;
    logic signed [spbb_pkg::ARITH_W-1:0] prev_x;
    logic signed [spbb_pkg::ARITH_W-1:0] p_once;
    logic signed [spbb_pkg::ARITH_W-1:0] p_pos;
    logic signed [spbb_pkg::ARITH_W-1:0] p_sgn;
    logic signed [spbb_pkg::ARITH_W-1:0] diff;
    logic signed [spbb_pkg::ARITH_W-1:0] adiff;
    logic signed [spbb_pkg::ARITH_W-1:0] wrap;
    logic signed [spbb_pkg::ARITH_W-1:0] mag;
    logic signed [spbb_pkg::ARITH_W-1:0] step;
    logic        [2:0]                   qcnt;
    logic                                accept;

    assign accept  = i_valid && !o_stall;
    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        lon_x  = {{(spbb_pkg::ARITH_W-spbb_pkg::LON_W){i_vertex_lon[spbb_pkg::LON_W-1]}},
                  i_vertex_lon};
        prev_x = {{(spbb_pkg::ARITH_W-spbb_pkg::LON_W){r_prev_lon[spbb_pkg::LON_W-1]}},
                  r_prev_lon};

        // at most two turns bring any input into the non-negative range
        p_once = (lon_x < 0) ? lon_x + spbb_pkg::FULL_TURN : lon_x;
        p_pos  = (p_once < 0) ? p_once + spbb_pkg::FULL_TURN : p_once;
        p_sgn  = (p_pos > spbb_pkg::HALF_TURN) ? p_pos - spbb_pkg::FULL_TURN : p_pos;

        // quadrant is floor(p / 90 deg) modulo 4
        qcnt = 3'(p_pos >= spbb_pkg::QUARTER_TURN) + 3'(p_pos >= spbb_pkg::HALF_TURN)
             + 3'(p_pos >= spbb_pkg::TRI_QUARTER) + 3'(p_pos >= spbb_pkg::FULL_TURN)
             + 3'(p_pos >= spbb_pkg::FIVE_QUARTER);

        diff  = lon_x - prev_x;
        adiff = (diff < 0) ? -diff : diff;
        wrap  = spbb_pkg::FULL_TURN - adiff;
        mag   = (wrap < 0) ? -wrap : wrap;
        if (adiff > spbb_pkg::HALF_TURN) begin
            step = (diff > 0) ? -mag : mag;
        end else begin
            step = diff;
        end

        n_word.pos  = p_pos[spbb_pkg::LON_W-1:0];
        n_word.sgn  = p_sgn[spbb_pkg::LON_W-1:0];
        n_word.quad = 4'b0001 << qcnt[1:0];
        n_word.step = step[spbb_pkg::STEP_W-1:0];
        n_word.lat  = i_vertex_lat;
        n_word.last = i_last_vertex;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_prev_lon <= '0;
        end else begin
            if (accept) begin
                r_valid    <= 1'b1;
                r_prev_lon <= i_vertex_lon;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= n_word;
        end
    end

endmodule

### hw/rtl/spbb_accum.sv
// ----------------------------------------------------------------------------
// spbb_accum: polygon accumulator
// Folds vertices after the first into extents, quadrant flags and sums; on the
// last vertex hands the finished state to the box stage and clears.
// ----------------------------------------------------------------------------
module spbb_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  spbb_pkg::t_vertex  i_word,
    output logic               o_take,
    input  logic               i_snap_take,
    output logic               o_snap_valid,
    output spbb_pkg::t_snap    o_snap
);

    logic            r_have_first;
    spbb_pkg::t_snap r_state;
    spbb_pkg::t_snap n_state;
    spbb_pkg::t_snap r_snap;
    logic            r_snap_valid;
    spbb_pkg::t_snap clear_state;

    logic signed [spbb_pkg::SUM_W:0]   step_add;
    logic signed [spbb_pkg::SUM_W:0]   lat_add;
    logic signed [spbb_pkg::SUM_W-1:0] step_sat;
    logic signed [spbb_pkg::SUM_W-1:0] lat_sat;

    assign o_take       = i_valid && (!i_word.last || !r_snap_valid || i_snap_take);
    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    always_comb begin
        clear_state           = '0;
        clear_state.lo_pos    = spbb_pkg::LON_FULL;
        clear_state.hi_pos    = spbb_pkg::LON_NEG_FULL;
        clear_state.lo_sgn    = spbb_pkg::LON_FULL;
        clear_state.hi_sgn    = spbb_pkg::LON_NEG_FULL;
    end

    always_comb begin
        step_add = {r_state.step_sum[spbb_pkg::SUM_W-1], r_state.step_sum}
                 + {{(spbb_pkg::SUM_W+1-spbb_pkg::STEP_W){i_word.step[spbb_pkg::STEP_W-1]}},
                    i_word.step};
        lat_add  = {r_state.lat_total[spbb_pkg::SUM_W-1], r_state.lat_total}
                 + {{(spbb_pkg::SUM_W+1-spbb_pkg::LAT_W){i_word.lat[spbb_pkg::LAT_W-1]}},
                    i_word.lat};

        // saturate where the top two bits disagree
        if (step_add[spbb_pkg::SUM_W] != step_add[spbb_pkg::SUM_W-1]) begin
            step_sat = step_add[spbb_pkg::SUM_W] ? spbb_pkg::SUM_MIN : spbb_pkg::SUM_MAX;
        end else begin
            step_sat = step_add[spbb_pkg::SUM_W-1:0];
        end
        if (lat_add[spbb_pkg::SUM_W] != lat_add[spbb_pkg::SUM_W-1]) begin
            lat_sat = lat_add[spbb_pkg::SUM_W] ? spbb_pkg::SUM_MIN : spbb_pkg::SUM_MAX;
        end else begin
            lat_sat = lat_add[spbb_pkg::SUM_W-1:0];
        end

        n_state = r_state;
        if (!r_have_first) begin
            // first vertex seeds the latitude extent only
            n_state.lat_low  = i_word.lat;
            n_state.lat_high = i_word.lat;
        end else begin
            if (i_word.pos < r_state.lo_pos) n_state.lo_pos = i_word.pos;
            if (i_word.pos > r_state.hi_pos) n_state.hi_pos = i_word.pos;
            if (i_word.sgn < r_state.lo_sgn) n_state.lo_sgn = i_word.sgn;
            if (i_word.sgn > r_state.hi_sgn) n_state.hi_sgn = i_word.sgn;
            if (i_word.lat < r_state.lat_low) n_state.lat_low = i_word.lat;
            if (i_word.lat > r_state.lat_high) n_state.lat_high = i_word.lat;
            n_state.quad      = r_state.quad | i_word.quad;
            n_state.step_sum  = step_sat;
            n_state.lat_total = lat_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_state      <= clear_state;
            r_snap_valid <= 1'b0;
        end else begin
            if (o_take) begin
                if (i_word.last) begin
                    r_have_first <= 1'b0;
                    r_state      <= clear_state;
                    r_snap_valid <= 1'b1;
                end else begin
                    r_have_first <= 1'b1;
                    r_state      <= n_state;
                    if (i_snap_take) r_snap_valid <= 1'b0;
                end
            end else if (i_snap_take) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_word.last) begin
            r_snap <= n_state;
        end
    end

endmodule

### hw/rtl/spbb_box.sv
// ----------------------------------------------------------------------------
// spbb_box: box builder and result register
// Runs the pole test on the finished polygon state, picks the longitude
// convention from the quadrant flags and spans and holds the result word.
// ----------------------------------------------------------------------------
module spbb_box (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_snap_valid,
    input  spbb_pkg::t_snap                       i_snap,
    output logic                                  o_snap_take,
    input  logic [spbb_pkg::TOL_W-1:0]            i_pole_tolerance,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [spbb_pkg::LON_W-1:0]     o_west_lon,
    output logic signed [spbb_pkg::LON_W-1:0]     o_east_lon,
    output logic signed [spbb_pkg::LAT_W-1:0]     o_south_lat,
    output logic signed [spbb_pkg::LAT_W-1:0]     o_north_lat,
    output logic signed [1:0]                     o_pole_code
);

    logic                                r_valid;
    logic signed [spbb_pkg::LON_W-1:0]   r_west;
    logic signed [spbb_pkg::LON_W-1:0]   r_east;
    logic signed [spbb_pkg::LAT_W-1:0]   r_south;
    logic signed [spbb_pkg::LAT_W-1:0]   r_north;
    logic signed [1:0]                   r_pole;

    logic signed [spbb_pkg::LON_W-1:0]   n_west;
    logic signed [spbb_pkg::LON_W-1:0]   n_east;
    logic signed [spbb_pkg::LAT_W-1:0]   n_south;
    logic signed [spbb_pkg::LAT_W-1:0]   n_north;
    logic signed [1:0]                   n_pole;

    logic signed [spbb_pkg::SUM_W:0]     sum_x;
    logic signed [spbb_pkg::SUM_W:0]     sum_abs;
    logic signed [spbb_pkg::SUM_W:0]     dev;
    logic signed [spbb_pkg::SUM_W:0]     dev_abs;
    logic                                pole_hit;
    logic signed [spbb_pkg::LON_W:0]     span_pos;
    logic signed [spbb_pkg::LON_W:0]     span_sgn;
    logic [2:0]                          nq;
    logic                                use_signed;
    logic signed [spbb_pkg::ARITH_W-1:0] w;
    logic signed [spbb_pkg::ARITH_W-1:0] e;
    logic signed [spbb_pkg::ARITH_W-1:0] w_adj;
    logic signed [spbb_pkg::ARITH_W-1:0] w_fin;
    logic signed [spbb_pkg::ARITH_W-1:0] e_fin;

    assign o_snap_take = i_snap_valid && (!r_valid || !i_stall);
    assign o_valid     = r_valid;
    assign o_west_lon  = r_west;
    assign o_east_lon  = r_east;
    assign o_south_lat = r_south;
    assign o_north_lat = r_north;
    assign o_pole_code = r_pole;

    always_comb begin
        sum_x   = {i_snap.step_sum[spbb_pkg::SUM_W-1], i_snap.step_sum};
        sum_abs = (sum_x < 0) ? -sum_x : sum_x;
        dev     = sum_abs - (spbb_pkg::SUM_W+1)'(spbb_pkg::FULL_TURN);
        dev_abs = (dev < 0) ? -dev : dev;
        pole_hit = (dev_abs <= $signed({1'b0, (spbb_pkg::SUM_W)'(i_pole_tolerance)}));

        span_pos = {i_snap.hi_pos[spbb_pkg::LON_W-1], i_snap.hi_pos}
                 - {i_snap.lo_pos[spbb_pkg::LON_W-1], i_snap.lo_pos};
        span_sgn = {i_snap.hi_sgn[spbb_pkg::LON_W-1], i_snap.hi_sgn}
                 - {i_snap.lo_sgn[spbb_pkg::LON_W-1], i_snap.lo_sgn};
        nq = 3'(i_snap.quad[0]) + 3'(i_snap.quad[1]) + 3'(i_snap.quad[2])
           + 3'(i_snap.quad[3]);

        // straddling zero favors -180..180, straddling 180 favors 0..360;
        // opposite quadrants go to the narrower span
        if (i_snap.quad[0] && i_snap.quad[3]) begin
            use_signed = 1'b1;
        end else if (i_snap.quad[1] && i_snap.quad[2]) begin
            use_signed = 1'b0;
        end else if (nq == 3'd2 && ((i_snap.quad[0] && i_snap.quad[2]) ||
                                    (i_snap.quad[1] && i_snap.quad[3]))) begin
            use_signed = !(span_pos < span_sgn);
        end else begin
            use_signed = 1'b0;
        end

        if (use_signed) begin
            w = {{(spbb_pkg::ARITH_W-spbb_pkg::LON_W){i_snap.lo_sgn[spbb_pkg::LON_W-1]}},
                 i_snap.lo_sgn};
            e = {{(spbb_pkg::ARITH_W-spbb_pkg::LON_W){i_snap.hi_sgn[spbb_pkg::LON_W-1]}},
                 i_snap.hi_sgn};
        end else begin
            w = {{(spbb_pkg::ARITH_W-spbb_pkg::LON_W){i_snap.lo_pos[spbb_pkg::LON_W-1]}},
                 i_snap.lo_pos};
            e = {{(spbb_pkg::ARITH_W-spbb_pkg::LON_W){i_snap.hi_pos[spbb_pkg::LON_W-1]}},
                 i_snap.hi_pos};
        end
        w_adj = (w > e) ? w - spbb_pkg::FULL_TURN : w;
        if (w_adj < 0 && e < 0) begin
            w_fin = w_adj + spbb_pkg::FULL_TURN;
            e_fin = e + spbb_pkg::FULL_TURN;
        end else begin
            w_fin = w_adj;
            e_fin = e;
        end

        n_south = i_snap.lat_low;
        n_north = i_snap.lat_high;
        if (pole_hit) begin
            if (i_snap.lat_total < 0) begin
                n_pole  = spbb_pkg::POLE_SOUTH;
                n_south = spbb_pkg::LAT_SOUTH;
            end else begin
                n_pole  = spbb_pkg::POLE_NORTH;
                n_north = spbb_pkg::LAT_NORTH;
            end
            n_west = '0;
            n_east = spbb_pkg::LON_FULL;
        end else begin
            n_pole = spbb_pkg::POLE_NONE;
            n_west = w_fin[spbb_pkg::LON_W-1:0];
            n_east = e_fin[spbb_pkg::LON_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (o_snap_take) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_west  <= n_west;
            r_east  <= n_east;
            r_south <= n_south;
            r_north <= n_north;
            r_pole  <= n_pole;
        end
    end

endmodule
